// ===== hw/rtl/bcomp_pkg.sv =====
package bcomp_pkg;

    localparam int DIV_W = 32;

    localparam logic [2:0] REG_OSS  = 3'd0;
    localparam logic [2:0] REG_C12  = 3'd1;
    localparam logic [2:0] REG_C34  = 3'd2;
    localparam logic [2:0] REG_C56  = 3'd3;
    localparam logic [2:0] REG_B12  = 3'd4;
    localparam logic [2:0] REG_MCMD = 3'd5;

    localparam logic signed [31:0] B6_OFS   = 32'sd4000;
    localparam logic signed [31:0] K_3038   = 32'sd3038;
    localparam logic signed [31:0] K_M7357  = -32'sd7357;
    localparam logic signed [31:0] K_3791   = 32'sd3791;
    localparam logic [31:0]        K_50000  = 32'd50000;
    localparam logic [31:0]        K_HALF   = 32'h8000_0000;
    localparam logic signed [31:0] K_32768  = 32'sd32768;
    localparam logic signed [31:0] T_MAX    = 32'sd32767;
    localparam logic signed [31:0] T_MIN    = -32'sd32768;
    localparam logic signed [31:0] P_MAX    = 32'sd262143;

    function automatic logic signed [31:0] sx16(input logic [15:0] v);
        sx16 = signed'({{16{v[15]}}, v});
    endfunction

    function automatic logic signed [31:0] zx16(input logic [15:0] v);
        zx16 = signed'({16'd0, v});
    endfunction

endpackage

// ===== hw/rtl/bcomp_div.sv =====
module bcomp_div #(
    parameter int SIDE_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_vld,
    input  logic [bcomp_pkg::DIV_W-1:0]  i_num,
    input  logic [bcomp_pkg::DIV_W-1:0]  i_den,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_vld,
    output logic [bcomp_pkg::DIV_W-1:0]  o_quo,
    output logic [SIDE_W-1:0]            o_side
);
    localparam int W = bcomp_pkg::DIV_W;

    logic         r_vld  [0:W];
    logic [W-1:0] r_rem  [0:W];
    logic [W-1:0] r_quo  [0:W];
    logic [W-1:0] r_num  [0:W];
    logic [W-1:0] r_den  [0:W];
    logic [SIDE_W-1:0] r_side [0:W];

    always_comb begin
        r_vld[0]  = i_vld;
        r_rem[0]  = '0;
        r_quo[0]  = '0;
        r_num[0]  = i_num;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            logic [W:0]   n_shf;
            logic [W:0]   n_dif;
            logic         n_ge;

            // one quotient bit per stage, msb first
            always_comb begin
                n_shf = {r_rem[k], r_num[k][W-1-k]};
                n_dif = n_shf - {1'b0, r_den[k]};
                n_ge  = !n_dif[W];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_ce) begin
                    r_vld[k+1] <= r_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k+1]  <= n_ge ? n_dif[W-1:0] : n_shf[W-1:0];
                    r_quo[k+1]  <= {r_quo[k][W-2:0], n_ge};
                    r_num[k+1]  <= r_num[k];
                    r_den[k+1]  <= r_den[k];
                    r_side[k+1] <= r_side[k];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[W];
    assign o_quo  = r_quo[W];
    assign o_side = r_side[W];

endmodule

// ===== hw/rtl/barometric_compensation_core.sv =====
// throughput: one item per cycle; the whole pipeline holds while a result waits
// two 32-stage restoring dividers (one quotient bit per stage) set the depth
// reset: synchronous active-low i_rst_n clears valid bits and calibration
// registers to zero
module barometric_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // temperature_tenths[15:0], pressure_pa[33:16], zero pad
    output logic [0:0]  o_m_tuser,   // error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int S1W = 32 + 19 + 1 + 1;
    localparam int S2W = 16 + 1 + 1;

    logic [1:0]  r_oss;
    logic [31:0] r_c12, r_c34, r_c56, r_b12, r_mcmd;

    logic ce;
    assign ce          = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = ce;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss  <= '0;
            r_c12  <= '0;
            r_c34  <= '0;
            r_c56  <= '0;
            r_b12  <= '0;
            r_mcmd <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bcomp_pkg::REG_OSS:  r_oss  <= i_cfg_data[1:0];
                bcomp_pkg::REG_C12:  r_c12  <= i_cfg_data;
                bcomp_pkg::REG_C34:  r_c34  <= i_cfg_data;
                bcomp_pkg::REG_C56:  r_c56  <= i_cfg_data;
                bcomp_pkg::REG_B12:  r_b12  <= i_cfg_data;
                bcomp_pkg::REG_MCMD: r_mcmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = bcomp_pkg::sx16(r_c12[31:16]);
    assign ac2 = bcomp_pkg::sx16(r_c12[15:0]);
    assign ac3 = bcomp_pkg::sx16(r_c34[31:16]);
    assign ac4 = bcomp_pkg::zx16(r_c34[15:0]);
    assign ac5 = bcomp_pkg::zx16(r_c56[31:16]);
    assign ac6 = bcomp_pkg::zx16(r_c56[15:0]);
    assign b1  = bcomp_pkg::sx16(r_b12[31:16]);
    assign b2  = bcomp_pkg::sx16(r_b12[15:0]);
    assign mc  = bcomp_pkg::sx16(r_mcmd[31:16]);
    assign md  = bcomp_pkg::sx16(r_mcmd[15:0]);

    // stage 1: raw temperature product
    logic               r1_vld;
    logic signed [31:0] r1_prod;
    logic [18:0]        r1_up;
    logic signed [31:0] n1_diff;
    assign n1_diff = bcomp_pkg::zx16(i_s_tdata[15:0]) - ac6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (ce) r1_vld <= i_s_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_prod <= n1_diff * ac5;
            r1_up   <= i_s_tdata[34:16];
        end
    end

    // stage 2: magnitudes and sign of the temperature division operands
    logic               r2_vld;
    logic [31:0]        r2_num, r2_den;
    logic [S1W-1:0]     r2_side;
    logic signed [31:0] n2_x1, n2_d, n2_n;
    logic               n2_neg, n2_dz;
    always_comb begin
        n2_x1  = r1_prod >>> 15;
        n2_d   = n2_x1 + md;
        n2_n   = mc <<< 11;
        n2_neg = n2_n[31] ^ n2_d[31];
        n2_dz  = (n2_d == 32'sd0);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (ce) r2_vld <= r1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_num  <= n2_n[31] ? 32'(-n2_n) : n2_n;
            r2_den  <= n2_dz ? 32'd1 : (n2_d[31] ? 32'(-n2_d) : n2_d);
            r2_side <= {n2_x1, r1_up, n2_neg, n2_dz};
        end
    end

    logic           d1_vld;
    logic [31:0]    d1_quo;
    logic [S1W-1:0] d1_side;
    bcomp_div #(.SIDE_W(S1W)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (ce),
        .i_vld  (r2_vld),
        .i_num  (r2_num),
        .i_den  (r2_den),
        .i_side (r2_side),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_side (d1_side)
    );

    // stage 3: b5, temperature, b6
    logic               r3_vld, r3_err;
    logic signed [31:0] r3_b6;
    logic [15:0]        r3_t;
    logic [18:0]        r3_up;
    logic signed [31:0] n3_x1, n3_x2, n3_b5, n3_t;
    always_comb begin
        n3_x1 = signed'(d1_side[S1W-1 -: 32]);
        n3_x2 = d1_side[1] ? signed'(32'(-d1_quo)) : signed'(d1_quo);
        n3_b5 = n3_x1 + n3_x2;
        n3_t  = (n3_b5 + 32'sd8) >>> 4;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (ce) r3_vld <= d1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_err <= d1_side[0];
            r3_b6  <= n3_b5 - bcomp_pkg::B6_OFS;
            r3_up  <= d1_side[20:2];
            if (n3_t > bcomp_pkg::T_MAX)      r3_t <= bcomp_pkg::T_MAX[15:0];
            else if (n3_t < bcomp_pkg::T_MIN) r3_t <= bcomp_pkg::T_MIN[15:0];
            else                              r3_t <= n3_t[15:0];
        end
    end

    // stage 4: products of b6
    logic               r4_vld, r4_err;
    logic signed [31:0] r4_sq, r4_a2, r4_a3;
    logic [15:0]        r4_t;
    logic [18:0]        r4_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else if (ce) r4_vld <= r3_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r4_sq  <= r3_b6 * r3_b6;
            r4_a2  <= ac2 * r3_b6;
            r4_a3  <= ac3 * r3_b6;
            r4_err <= r3_err;
            r4_t   <= r3_t;
            r4_up  <= r3_up;
        end
    end

    // stage 5: products of the square term
    logic               r5_vld, r5_err;
    logic signed [31:0] r5_p2, r5_p1, r5_x2a, r5_x1c;
    logic [15:0]        r5_t;
    logic [18:0]        r5_up;
    logic signed [31:0] n5_sq;
    assign n5_sq = r4_sq >>> 12;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else if (ce) r5_vld <= r4_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_p2  <= b2 * n5_sq;
            r5_p1  <= b1 * n5_sq;
            r5_x2a <= r4_a2 >>> 11;
            r5_x1c <= r4_a3 >>> 13;
            r5_err <= r4_err;
            r5_t   <= r4_t;
            r5_up  <= r4_up;
        end
    end

    // stage 6: b3 and the b4 factor
    logic               r6_vld, r6_err;
    logic signed [31:0] r6_b3, r6_xb;
    logic [15:0]        r6_t;
    logic [18:0]        r6_up;
    logic signed [31:0] n6_x3, n6_v, n6_x3b;
    always_comb begin
        n6_x3  = (r5_p2 >>> 11) + r5_x2a;
        n6_v   = (((ac1 <<< 2) + n6_x3) <<< r_oss) + 32'sd2;
        n6_x3b = (r5_x1c + (r5_p1 >>> 16) + 32'sd2) >>> 2;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else if (ce) r6_vld <= r5_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r6_b3  <= n6_v[31] ? ((n6_v + 32'sd3) >>> 2) : (n6_v >>> 2);
            r6_xb  <= n6_x3b + bcomp_pkg::K_32768;
            r6_err <= r5_err;
            r6_t   <= r5_t;
            r6_up  <= r5_up;
        end
    end

    // stage 7: b4 product and the b7 difference
    logic        r7_vld, r7_err;
    logic [31:0] r7_b4p, r7_dif;
    logic [15:0] r7_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_vld <= 1'b0;
        else if (ce) r7_vld <= r6_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r7_b4p <= unsigned'(ac4) * unsigned'(r6_xb);
            r7_dif <= {13'd0, r6_up} - unsigned'(r6_b3);
            r7_err <= r6_err;
            r7_t   <= r6_t;
        end
    end

    // stage 8: b4, b7 and the zero-b4 error
    logic        r8_vld, r8_err;
    logic [31:0] r8_b4, r8_b7;
    logic [15:0] r8_t;
    logic [31:0] n8_b4;
    assign n8_b4 = r7_b4p >> 15;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_vld <= 1'b0;
        else if (ce) r8_vld <= r7_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r8_b4  <= n8_b4;
            r8_b7  <= r7_dif * (bcomp_pkg::K_50000 >> r_oss);
            r8_err <= r7_err || (n8_b4 == 32'd0);
            r8_t   <= r7_t;
        end
    end

    // stage 9: pressure division operands
    logic           r9_vld;
    logic [31:0]    r9_num, r9_den;
    logic [S2W-1:0] r9_side;
    logic           n9_big;
    assign n9_big = (r8_b7 >= bcomp_pkg::K_HALF);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_vld <= 1'b0;
        else if (ce) r9_vld <= r8_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r9_num  <= n9_big ? r8_b7 : (r8_b7 << 1);
            r9_den  <= (r8_b4 == 32'd0) ? 32'd1 : r8_b4;
            r9_side <= {r8_t, r8_err, n9_big};
        end
    end

    logic           d2_vld;
    logic [31:0]    d2_quo;
    logic [S2W-1:0] d2_side;
    bcomp_div #(.SIDE_W(S2W)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (ce),
        .i_vld  (r9_vld),
        .i_num  (r9_num),
        .i_den  (r9_den),
        .i_side (r9_side),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_side (d2_side)
    );

    // stage 10: correction products
    logic               r10_vld, r10_err;
    logic signed [31:0] r10_p, r10_sq, r10_m2;
    logic [15:0]        r10_t;
    logic signed [31:0] n10_p, n10_a;
    always_comb begin
        n10_p = d2_side[0] ? signed'(d2_quo << 1) : signed'(d2_quo);
        n10_a = n10_p >>> 8;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_vld <= 1'b0;
        else if (ce) r10_vld <= d2_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r10_p   <= n10_p;
            r10_sq  <= n10_a * n10_a;
            r10_m2  <= bcomp_pkg::K_M7357 * n10_p;
            r10_err <= d2_side[1];
            r10_t   <= d2_side[S2W-1 -: 16];
        end
    end

    // stage 11
    logic               r11_vld, r11_err;
    logic signed [31:0] r11_p, r11_m1, r11_x2;
    logic [15:0]        r11_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r11_vld <= 1'b0;
        else if (ce) r11_vld <= r10_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r11_p   <= r10_p;
            r11_m1  <= r10_sq * bcomp_pkg::K_3038;
            r11_x2  <= r10_m2 >>> 16;
            r11_err <= r10_err;
            r11_t   <= r10_t;
        end
    end

    // stage 12: final pressure, saturation, output register
    logic               r_out_vld, r_out_err;
    logic [15:0]        r_out_t;
    logic [17:0]        r_out_p;
    logic signed [31:0] n12_p;
    assign n12_p = r11_p +
                   (((r11_m1 >>> 16) + r11_x2 + bcomp_pkg::K_3791) >>> 4);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (ce) r_out_vld <= r11_vld;
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_err <= r11_err;
            r_out_t   <= r11_err ? 16'd0 : r11_t;
            if (r11_err || n12_p[31])          r_out_p <= '0;
            else if (n12_p > bcomp_pkg::P_MAX) r_out_p <= bcomp_pkg::P_MAX[17:0];
            else                               r_out_p <= n12_p[17:0];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_out_p, r_out_t};
    assign o_m_tuser  = r_out_err;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 76;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [17:0]        pressure;
        logic               error;
    } t_comp_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    logic [1:0]  oss_setting;
    logic [31:0] cal_regs [1:5];

    t_comp_result expected_results[$];
    int fail_count;
    int items_sent;
    int results_seen;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    barometric_compensation_core i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // arithmetic helpers, 32-bit wrapping semantics
    function automatic logic signed [31:0] asr(input logic signed [31:0] a, input int s);
        return a >>> s;
    endfunction

    function automatic logic signed [31:0] div_trunc(input logic signed [31:0] n,
                                                     input logic signed [31:0] d);
        logic [31:0] un, ud, q;
        un = n[31] ? -n : n;
        ud = d[31] ? -d : d;
        q = un / ud;
        if (n[31] != d[31]) q = -q;
        return signed'(q);
    endfunction

    function automatic t_comp_result compensate(input logic [15:0] ut, input logic [18:0] up);
        t_comp_result r;
        logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic signed [31:0] x1, x2, x3, b5, b6, b3, t, p, sq;
        logic [31:0] b4, b7, pu;
        r = '{temperature: '0, pressure: '0, error: 1'b1};
        ac1 = {{16{cal_regs[1][31]}}, cal_regs[1][31:16]};
        ac2 = {{16{cal_regs[1][15]}}, cal_regs[1][15:0]};
        ac3 = {{16{cal_regs[2][31]}}, cal_regs[2][31:16]};
        ac4 = {16'd0, cal_regs[2][15:0]};
        ac5 = {16'd0, cal_regs[3][31:16]};
        ac6 = {16'd0, cal_regs[3][15:0]};
        b1 = {{16{cal_regs[4][31]}}, cal_regs[4][31:16]};
        b2 = {{16{cal_regs[4][15]}}, cal_regs[4][15:0]};
        mc = {{16{cal_regs[5][31]}}, cal_regs[5][31:16]};
        md = {{16{cal_regs[5][15]}}, cal_regs[5][15:0]};
        x1 = asr((signed'({16'd0, ut}) - ac6) * ac5, 15);
        x2 = x1 + md;
        if (x2 == 0) return r;
        x2 = div_trunc(mc <<< 11, x2);
        b5 = x1 + x2;
        t = asr(b5 + 8, 4);
        b6 = b5 - 4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_trunc(((ac1 * 4 + x3) <<< oss_setting) + 2, 4);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 2, 2);
        b4 = (ac4 * (x3 + 32768)) >> 15;
        if (b4 == 0) return r;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> oss_setting);
        if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
        else pu = (b7 / b4) * 2;
        p = signed'(pu);
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 3038, 16);
        x2 = asr(-32'sd7357 * p, 16);
        p = p + asr(x1 + x2 + 3791, 4);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (p < 0) p = 0;
        if (p > 262143) p = 262143;
        r.temperature = t[15:0];
        r.pressure = p[17:0];
        r.error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic send_sample(input logic [15:0] ut, input logic [18:0] up);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {5'd0, up, ut};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_results.push_back(compensate(ut, up));
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == bcomp_pkg::REG_OSS) oss_setting = val[1:0];
        else cal_regs[idx] = val;
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_calibration(input logic [1:0] oss, input logic [31:0] c12,
                                    input logic [31:0] c34, input logic [31:0] c56,
                                    input logic [31:0] b12, input logic [31:0] mcmd);
        drain();
        write_reg(bcomp_pkg::REG_OSS, {30'd0, oss});
        write_reg(bcomp_pkg::REG_C12, c12);
        write_reg(bcomp_pkg::REG_C34, c34);
        write_reg(bcomp_pkg::REG_C56, c56);
        write_reg(bcomp_pkg::REG_B12, b12);
        write_reg(bcomp_pkg::REG_MCMD, mcmd);
        i_cfg_valid <= 1'b0;
    endtask

    // datasheet-like coefficients
    task automatic load_typical(input logic [1:0] oss);
        load_calibration(oss, {16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                         {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                         {-16'sd8711, 16'sd2868});
    endtask

    task automatic test_directed;
        load_typical(2'd0);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'd0);
        send_sample(16'hffff, 19'h7ffff);
        send_sample(16'h8000, 19'h40000);
        load_typical(2'd3);
        send_sample(16'd27898, 19'd190744);
        send_sample(16'hffff, 19'd0);
        send_sample(16'd0, 19'h7ffff);
        // zero temperature divisor: ac5 zero gives x1 zero, md zero
        load_calibration(2'd1, 32'h0198_ffb8, 32'hc7d1_7fe5, 32'h0000_5a71,
                         32'h182e_0004, 32'hddf9_0000);
        send_sample(16'd1234, 19'd5000);
        // zero b4: ac4 zero
        load_calibration(2'd2, 32'h0198_ffb8, 32'hc7d1_0000, 32'h7ff5_5a71,
                         32'h182e_0004, 32'hddf9_0b34);
        send_sample(16'd27898, 19'd40000);
        // all-ones and extreme coefficients, pushing wrap, branch and saturation
        load_calibration(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                         32'hffff_ffff, 32'hffff_ffff);
        send_sample(16'h0000, 19'h00000);
        send_sample(16'hffff, 19'h7ffff);
        send_sample(16'h5555, 19'h2aaaa);
        load_calibration(2'd0, 32'h8000_7fff, 32'h7fff_ffff, 32'hffff_0001,
                         32'h8000_8000, 32'h7fff_8001);
        send_sample(16'h0000, 19'h7ffff);
        send_sample(16'hffff, 19'h00000);
        send_sample(16'haaaa, 19'h55555);
        load_calibration(2'd1, 32'h7fff_8000, 32'h8000_8000, 32'h0001_ffff,
                         32'h7fff_7fff, 32'h8000_7fff);
        send_sample(16'h1234, 19'h7ffff);
        send_sample(16'hfedc, 19'h00001);
    endtask

    task automatic test_random_phase(input int count, input int sidle, input int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                if ($urandom_range(3) == 0)
                    load_calibration(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                                     $urandom, $urandom);
                else
                    load_typical(2'($urandom_range(3)));
            end
            if ($urandom_range(3) == 0)
                send_sample(16'($urandom), 19'($urandom));
            else
                send_sample(16'($urandom_range(22000, 34000)),
                            19'($urandom_range(15000, 24000) << oss_setting));
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_comp_result got, exp;
            results_seen++;
            got.temperature = o_m_tdata[15:0];
            got.pressure = o_m_tdata[33:16];
            got.error = o_m_tuser[0];
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                exp = expected_results.pop_front();
                if (got.temperature !== exp.temperature)
                    report_mismatch($sformatf("temperature %0d expected %0d",
                                              got.temperature, exp.temperature));
                if (got.pressure !== exp.pressure)
                    report_mismatch($sformatf("pressure %0d expected %0d",
                                              got.pressure, exp.pressure));
                if (got.error !== exp.error)
                    report_mismatch($sformatf("error %0b expected %0b",
                                              got.error, exp.error));
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_m_tready <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        oss_setting = '0;
        for (int k = 1; k <= 5; k++) cal_regs[k] = '0;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset coefficients give a zero divisor
        send_sample(16'd100, 19'd100);
        test_directed();
        test_random_phase(200, 0, 0);
        test_random_phase(200, 46, 0);
        test_random_phase(200, 0, 46);
        test_random_phase(200, 17, 17);
        drain();
        $display("covered %0d input items and %0d results", items_sent, results_seen);
        $display("over four handshake pressure phases and all oversampling settings");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
